FILE: rtl/utrd_pkg.sv
package utrd_pkg;

  localparam int MAX_ROWS   = 256;
  localparam int ROWS_W     = 9;
  localparam int OP_LIMIT   = 30;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(64);
  localparam logic [ROWS_W-1:0] ROWS_CAP   = ROWS_W'(MAX_ROWS);

  localparam logic [1:0] KIND_ROW  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ERR_TRUNC     = 3'd2;
  localparam logic [2:0] ERR_ROWS      = 3'd3;
  localparam logic [2:0] ERR_OPCODE    = 3'd4;
  localparam logic [2:0] ERR_NO_VALUE  = 3'd5;
  localparam logic [2:0] ERR_VALUE_FF  = 3'd6;

  localparam logic [0:0] REG_ROWS_IN_TRACK = 1'd0;

  typedef struct packed {
    logic [3:0] nrows;
    logic [7:0] row_start;
    logic [7:0] note;
    logic [7:0] ins;
    logic [4:0] eff;
    logic [7:0] par;
    logic       has_tail;
    logic [1:0] tail_kind;
    logic [2:0] err;
  } cmd_t;

  function automatic logic [4:0] xm_remap(input logic [1:0] sel);
    logic [4:0] r;
    unique case (sel)
      2'd0: r = 5'd10;
      2'd1: r = 5'd16;
      2'd2: r = 5'd17;
      2'd3: r = 5'd25;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/utrd_front.sv
module utrd_front import utrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        code,
  input  logic              fin,
  input  logic              room,
  input  logic [ROWS_W-1:0] rows_in_track,
  output logic              push,
  output cmd_t              cmd
);

  localparam logic [2:0] PH_DESC   = 3'd0;
  localparam logic [2:0] PH_OPCODE = 3'd1;
  localparam logic [2:0] PH_VALUE  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DRAIN  = 3'd4;

  logic [2:0]        phase, phase_next;
  logic [4:0]        gbl, gbl_next;
  logic [3:0]        rep, rep_next;
  logic [ROWS_W-1:0] row_cnt, row_cnt_next;
  logic [4:0]        op, op_next;
  logic [7:0]        note, note_next;
  logic [7:0]        ins, ins_next;
  logic [4:0]        eff, eff_next;
  logic [7:0]        par, par_next;
  logic [2:0]        fault, fault_next;

  logic              accept;
  logic              do_close;
  logic              do_trunc;
  logic [ROWS_W-1:0] limit;
  logic [ROWS_W-1:0] avail;
  logic [4:0]        size;

  assign accept = in_valid && room;
  assign size   = code[4:0];
  assign limit  = (rows_in_track > ROWS_CAP) ? ROWS_CAP : rows_in_track;
  assign avail  = (row_cnt < limit) ? (limit - row_cnt) : '0;

  always_comb begin
    phase_next   = phase;
    gbl_next     = gbl;
    rep_next     = rep;
    row_cnt_next = row_cnt;
    op_next      = op;
    note_next    = note;
    ins_next     = ins;
    eff_next     = eff;
    par_next     = par;
    fault_next   = fault;
    push         = 1'b0;
    cmd          = '0;
    do_close     = 1'b0;
    do_trunc     = 1'b0;
    if (accept) begin
      if (phase == PH_DRAIN) begin
        if (fin) begin
          phase_next   = PH_DESC;
          row_cnt_next = '0;
        end
      end else if (phase == PH_DESC) begin
        if (code == 8'd0) begin
          push          = 1'b1;
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_DONE;
          phase_next    = fin ? PH_DESC : PH_DRAIN;
          if (fin) begin
            row_cnt_next = '0;
          end
        end else if (size == 5'd0) begin
          push          = 1'b1;
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_FAIL;
          cmd.err       = ERR_ZERO_SIZE;
          phase_next    = fin ? PH_DESC : PH_DRAIN;
          if (fin) begin
            row_cnt_next = '0;
          end
        end else begin
          gbl_next   = size - 5'd1;
          rep_next   = {1'b0, code[7:5]} + 4'd1;
          op_next    = '0;
          note_next  = '0;
          ins_next   = '0;
          eff_next   = '0;
          par_next   = '0;
          fault_next = ERR_NONE;
          phase_next = PH_OPCODE;
          if (gbl_next == 5'd0) begin
            do_close = 1'b1;
          end else if (fin) begin
            do_trunc = 1'b1;
          end
        end
      end else begin
        if (gbl != 5'd0) begin
          gbl_next = gbl - 5'd1;
        end
        if (phase == PH_OPCODE) begin
          if (code == 8'd0) begin
            phase_next = PH_SKIP;
          end else if (code >= 8'(OP_LIMIT)) begin
            fault_next = ERR_OPCODE;
            phase_next = PH_SKIP;
          end else if (gbl_next == 5'd0) begin
            fault_next = ERR_NO_VALUE;
            phase_next = PH_SKIP;
          end else begin
            op_next    = code[4:0];
            phase_next = PH_VALUE;
          end
        end else if (phase == PH_VALUE) begin
          phase_next = PH_OPCODE;
          if (op == 5'd1 || op == 5'd2) begin
            if (code == 8'hFF) begin
              fault_next = ERR_VALUE_FF;
              phase_next = PH_SKIP;
            end else if (op == 5'd1) begin
              note_next = code + 8'd1;
            end else begin
              ins_next = code + 8'd1;
            end
          end else if (op >= 5'd3 && op <= 5'd18) begin
            eff_next = op - 5'd3;
            par_next = code;
          end else if (op >= 5'd26 && op <= 5'd29) begin
            eff_next = xm_remap(op[1:0] - 2'd2);
            par_next = code;
          end
        end
        if (gbl_next == 5'd0) begin
          do_close = 1'b1;
        end else if (fin) begin
          do_trunc = 1'b1;
        end
      end

      if (do_trunc) begin
        push          = 1'b1;
        cmd.has_tail  = 1'b1;
        cmd.tail_kind = KIND_FAIL;
        cmd.err       = ERR_TRUNC;
        phase_next    = fin ? PH_DESC : PH_DRAIN;
        row_cnt_next  = '0;
      end else if (do_close) begin
        push = 1'b1;
        if ({{(ROWS_W-4){1'b0}}, rep_next} > avail) begin
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_FAIL;
          cmd.err       = ERR_ROWS;
          phase_next    = fin ? PH_DESC : PH_DRAIN;
          if (fin) begin
            row_cnt_next = '0;
          end
        end else if (fault_next != ERR_NONE) begin
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_FAIL;
          cmd.err       = fault_next;
          phase_next    = fin ? PH_DESC : PH_DRAIN;
          if (fin) begin
            row_cnt_next = '0;
          end
        end else begin
          cmd.nrows     = rep_next;
          cmd.row_start = row_cnt[7:0];
          cmd.note      = note_next;
          cmd.ins       = ins_next;
          cmd.eff       = eff_next;
          cmd.par       = par_next;
          cmd.has_tail  = fin;
          cmd.tail_kind = KIND_DONE;
          phase_next    = PH_DESC;
          row_cnt_next  = fin ? '0 : row_cnt + {{(ROWS_W-4){1'b0}}, rep_next};
          rep_next      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_DESC;
      gbl     <= '0;
      rep     <= '0;
      row_cnt <= '0;
      op      <= '0;
      note    <= '0;
      ins     <= '0;
      eff     <= '0;
      par     <= '0;
      fault   <= ERR_NONE;
    end else begin
      phase   <= phase_next;
      gbl     <= gbl_next;
      rep     <= rep_next;
      row_cnt <= row_cnt_next;
      op      <= op_next;
      note    <= note_next;
      ins     <= ins_next;
      eff     <= eff_next;
      par     <= par_next;
      fault   <= fault_next;
    end
  end

endmodule

FILE: rtl/utrd_cmd_fifo.sv
module utrd_cmd_fifo import utrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_full,
  output logic not_empty,
  output cmd_t head
);

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign not_full  = (count != FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/utrd_back.sv
module utrd_back import utrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd_in,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [39:0] out_data,
  output logic        out_last
);

  logic       busy;
  cmd_t       cur;
  logic [3:0] rows_left;
  logic [7:0] row_idx;
  logic       advance;

  assign advance = !out_valid || out_ready;
  assign cmd_pop = !busy && cmd_valid;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_in;
    end
    if (cmd_pop) begin
      rows_left <= cmd_in.nrows;
      row_idx   <= cmd_in.row_start;
    end else if (busy && advance && rows_left != 4'd0) begin
      rows_left <= rows_left - 4'd1;
      row_idx   <= row_idx + 8'd1;
    end
    if (busy && advance) begin
      if (rows_left != 4'd0) begin
        out_kind <= KIND_ROW;
        out_data <= {ERR_NONE, cur.par, cur.eff, cur.ins, cur.note, row_idx};
        out_last <= (rows_left == 4'd1) && !cur.has_tail;
      end else begin
        out_kind <= cur.tail_kind;
        out_data <= {cur.err, 37'd0};
        out_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy <= 1'b1;
      end else if (busy && advance) begin
        if (rows_left == 4'd0 || (rows_left == 4'd1 && !cur.has_tail)) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= busy;
      end
    end
  end

endmodule

FILE: rtl/uni_track_row_decoder.sv
// Channel   Role         Payload
// s_*       track bytes  tdata = code_byte; tlast = final_byte
// m_*       results      tuser = result_kind; tlast = run_end; tdata = row fields, error
// APB       register     rows_in_track at address 0
//
// A byte is taken whenever the two-entry command queue has room.
// Each result leaves the back end one per cycle unless m_tready holds the output;
// a command is loaded before its first beat, and no new one is taken until its last beat is issued.
// Reset clears parser state, the queue and the output valid flag.
// Output stalls back up into the queue and only then stop the byte input.
module uni_track_row_decoder import utrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // row_index, note_value, instrument_value,
                                 // effect_kind, effect_param, error_code
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ROWS_W-1:0] rows_in_track;
  logic              push;
  cmd_t              push_cmd;
  logic              q_room;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_head;
  logic              reg_hit;

  assign pready   = 1'b1;
  assign reg_hit  = (paddr[2:2] == REG_ROWS_IN_TRACK);
  assign prdata   = reg_hit ? {{(32-ROWS_W){1'b0}}, rows_in_track} : 32'd0;
  assign s_tready = q_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_track <= ROWS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      rows_in_track <= pwdata[ROWS_W-1:0];
    end
  end

  utrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .code          (s_tdata),
    .fin           (s_tlast),
    .room          (q_room),
    .rows_in_track (rows_in_track),
    .push          (push),
    .cmd           (push_cmd)
  );

  utrd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .not_full  (q_room),
    .not_empty (q_valid),
    .head      (q_head)
  );

  utrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_in    (q_head),
    .cmd_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

FILE: rtl/utrd_checker.sv
module utrd_checker import utrd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_ROW || m_tuser == KIND_DONE || m_tuser == KIND_FAIL))
    else $error("illegal result kind");

  a_row_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_FAIL |-> m_tdata[39:37] == ERR_NONE)
    else $error("error code on a non-failure beat");

  a_fail_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FAIL |-> m_tdata[39:37] != ERR_NONE)
    else $error("failure beat without an error code");

  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_ROW |-> m_tlast)
    else $error("track status beat not marked last");

endmodule

bind uni_track_row_decoder utrd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
